// ===== rtl/mbcp_pkg.sv =====
// Shared types, codes and defaults for the mail byte class profiler.
package mbcp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MID_DEPTH_DEF   = 4;
    localparam int OUT_DEPTH_DEF   = 4;

    localparam logic [15:0] LINE_LIMIT_RST = 16'd988;
    // divisor 5 stands for a control ratio limit of 0.2
    localparam logic [7:0]  CTL_DIV_RST    = 8'd5;

    localparam int PADDR_W     = 3;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic {
        REG_LINE_LIMIT = 1'b0,
        REG_CTL_DIV    = 1'b1
    } reg_sel_t;

    typedef enum logic [2:0] {
        CLS_NUL   = 3'd0,
        CLS_CR    = 3'd1,
        CLS_LF    = 3'd2,
        CLS_PRINT = 3'd3,
        CLS_CTL   = 3'd4,
        CLS_HIGH  = 3'd5
    } byte_class_t;

    typedef enum logic [2:0] {
        DC_BINARY        = 3'd0,
        DC_EIGHTBIT_DATA = 3'd1,
        DC_EIGHTBIT_TEXT = 3'd2,
        DC_SEVENBIT_DATA = 3'd3,
        DC_SEVENBIT_TEXT = 3'd4
    } data_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic        last;
    } item_t;

    typedef struct packed {
        data_class_t data_class;
        logic [31:0] total_bytes;
        logic [31:0] nul_bytes;
        logic [31:0] control_bytes;
        logic [31:0] printable_bytes;
        logic [31:0] high_bit_bytes;
        logic [31:0] cr_bytes;
        logic [31:0] lf_bytes;
        logic [31:0] crlf_pairs;
        logic [31:0] shortest_line;
        logic [31:0] longest_line;
    } result_t;

endpackage

// ===== rtl/mail_byte_class_profiler.sv =====
// Top level of the mail byte class profiler: config registers and block wiring.
//
// Bytes of a buffer enter through push/full, one item per cycle; an item is
// taken at a rising edge with push high and full low. last_byte marks the
// final byte of a buffer and produces one result: the data class and all
// counts. Results leave through empty/pop; the oldest result is on the ports
// while empty is low and is taken at an edge with pop high.
// Throughput: one byte per cycle while full is low, and a result may follow
// every cycle (even one-byte buffers) while pop keeps the output queue from
// filling; the counters update once per byte taken. A result becomes visible
// after byte queue, counter snapshot, control-ratio multiply and result queue.
// If the result side stalls, up to four results wait in the output queue;
// once it fills, the byte queue stops draining; full rises with four bytes held.
// Reset clears all counters and queues and loads line_limit = 988 and
// ctl_ratio_divisor = 5. Write the registers over APB only while idle.
module mail_byte_class_profiler #(
    parameter int COUNT_WIDTH = mbcp_pkg::COUNT_WIDTH_DEF,
    parameter int MID_DEPTH   = mbcp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH   = mbcp_pkg::OUT_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbcp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    output logic                         empty,
    input  logic                         pop,
    output logic [2:0]                   data_class,
    output logic [31:0]                  total_bytes,
    output logic [31:0]                  nul_bytes,
    output logic [31:0]                  control_bytes,
    output logic [31:0]                  printable_bytes,
    output logic [31:0]                  high_bit_bytes,
    output logic [31:0]                  cr_bytes,
    output logic [31:0]                  lf_bytes,
    output logic [31:0]                  crlf_pairs,
    output logic [31:0]                  shortest_line,
    output logic [31:0]                  longest_line
);

    logic [15:0] line_limit_reg;
    logic [7:0]  ctl_div_reg;
    logic        cfg_wr;
    mbcp_pkg::reg_sel_t reg_sel;

    mbcp_pkg::item_t   front_item;
    logic              front_push;
    mbcp_pkg::item_t   mid_item;
    logic              mid_empty;
    logic              mid_pop;
    mbcp_pkg::result_t res_in;
    mbcp_pkg::result_t res_out;
    logic              res_push;
    logic              res_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] res_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = mbcp_pkg::reg_sel_t'(paddr[mbcp_pkg::REG_SEL_BIT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= mbcp_pkg::LINE_LIMIT_RST;
            ctl_div_reg    <= mbcp_pkg::CTL_DIV_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                mbcp_pkg::REG_LINE_LIMIT: line_limit_reg <= pwdata[15:0];
                mbcp_pkg::REG_CTL_DIV:    ctl_div_reg    <= pwdata[7:0];
                default:                  line_limit_reg <= line_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            mbcp_pkg::REG_LINE_LIMIT: prdata = 32'(line_limit_reg);
            mbcp_pkg::REG_CTL_DIV:    prdata = 32'(ctl_div_reg);
            default:                  prdata = '0;
        endcase
    end

    mbcp_front u_front (
        .data_byte_valid (push),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .item_push       (front_push),
        .item            (front_item)
    );

    mbcp_queue #(
        .elem_t (mbcp_pkg::item_t),
        .DEPTH  (MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_item (front_item),
        .full    (full),
        .pop     (mid_pop),
        .rd_item (mid_item),
        .empty   (mid_empty),
        .level   ()
    );

    mbcp_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_item   (mid_item),
        .mid_empty  (mid_empty),
        .mid_pop    (mid_pop),
        .line_limit (line_limit_reg),
        .ctl_div    (ctl_div_reg),
        .out_level  (res_level),
        .out_push   (res_push),
        .out_item   (res_in)
    );

    mbcp_queue #(
        .elem_t (mbcp_pkg::result_t),
        .DEPTH  (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_item (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_item (res_out),
        .empty   (empty),
        .level   (res_level)
    );

    assign data_class      = res_out.data_class;
    assign total_bytes     = res_out.total_bytes;
    assign nul_bytes       = res_out.nul_bytes;
    assign control_bytes   = res_out.control_bytes;
    assign printable_bytes = res_out.printable_bytes;
    assign high_bit_bytes  = res_out.high_bit_bytes;
    assign cr_bytes        = res_out.cr_bytes;
    assign lf_bytes        = res_out.lf_bytes;
    assign crlf_pairs      = res_out.crlf_pairs;
    assign shortest_line   = res_out.shortest_line;
    assign longest_line    = res_out.longest_line;

    a_res_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed while output queue full");

    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr |=> ($stable(line_limit_reg) && $stable(ctl_div_reg)))
        else $error("config register changed without a write");

    a_res_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_pop && mid_item.last) |=> !res_full)
        else $error("result accepted without a reserved slot");

endmodule

// ===== rtl/mbcp_queue.sv =====
// Small register-based FIFO used between the front, the back and the result port.
module mbcp_queue #(
    parameter type elem_t = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  elem_t                        wr_item,
    output logic                         full,
    input  logic                         pop,
    output elem_t                        rd_item,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    elem_t slot_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign full    = (count_reg == LW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + LW'(1);
            2'b01:   count_next = count_reg - LW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/mbcp_front.sv =====
// Front end: sorts each incoming byte into its class.
module mbcp_front (
    input  logic            data_byte_valid,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            item_push,
    output mbcp_pkg::item_t item
);

    assign item_push = data_byte_valid;

    always_comb
    begin
        item.last = last_byte;
        // first match wins, so LF and CR are taken out before the control range
        case (data_byte) inside
            8'h00:                item.cls = mbcp_pkg::CLS_NUL;
            8'h0a:                item.cls = mbcp_pkg::CLS_LF;
            8'h0d:                item.cls = mbcp_pkg::CLS_CR;
            8'h09, [8'h20:8'h7e]: item.cls = mbcp_pkg::CLS_PRINT;
            [8'h01:8'h1f], 8'h7f: item.cls = mbcp_pkg::CLS_CTL;
            default:              item.cls = mbcp_pkg::CLS_HIGH;
        endcase
    end

endmodule

// ===== rtl/mbcp_back.sv =====
// Back end: per-buffer counters, line tracking and the class decision pipeline.
module mbcp_back #(
    parameter int COUNT_WIDTH = mbcp_pkg::COUNT_WIDTH_DEF,
    parameter int OUT_DEPTH   = mbcp_pkg::OUT_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mbcp_pkg::item_t                mid_item,
    input  logic                           mid_empty,
    output logic                           mid_pop,
    input  logic [15:0]                    line_limit,
    input  logic [7:0]                     ctl_div,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
    output logic                           out_push,
    output mbcp_pkg::result_t              out_item
);

    localparam int CW   = COUNT_WIDTH;
    localparam int PRW  = CW + 8;
    localparam int CMPW = (CW > 16) ? CW : 16;
    localparam int LW   = $clog2(OUT_DEPTH + 1);

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v, input logic en);
        logic [CW-1:0] r;
        r = v;
        if (en && !(&v))
        begin
            r = v + CW'(1);
        end
        return r;
    endfunction

    // running state
    logic          prev_cr_reg, prev_cr_next;
    logic [CW-1:0] line_len_reg, line_len_next;
    logic [CW-1:0] byte_reg, byte_next;
    logic [CW-1:0] nul_reg, nul_next;
    logic [CW-1:0] ctl_reg, ctl_next;
    logic [CW-1:0] print_reg, print_next;
    logic [CW-1:0] high_reg, high_next;
    logic [CW-1:0] cr_reg, cr_next;
    logic [CW-1:0] lf_reg, lf_next;
    logic [CW-1:0] crlf_reg, crlf_next;
    logic [CW-1:0] min_line_reg, min_line_next;
    logic [CW-1:0] max_line_reg, max_line_next;

    // snapshot stage
    logic          a_valid_reg;
    logic [CW-1:0] a_byte_reg, a_nul_reg, a_ctl_reg, a_print_reg, a_high_reg;
    logic [CW-1:0] a_cr_reg, a_lf_reg, a_crlf_reg, a_min_reg, a_max_reg;

    // product stage
    logic           b_valid_reg;
    logic [CW-1:0]  b_byte_reg, b_nul_reg, b_ctl_reg, b_print_reg, b_high_reg;
    logic [CW-1:0]  b_cr_reg, b_lf_reg, b_crlf_reg, b_min_reg, b_max_reg;
    logic [PRW-1:0] b_prod_reg;
    logic           b_data_pre_reg;

    logic          is_lf, is_cr;
    logic [CW-1:0] len_adj;
    logic [LW:0]   pending;
    logic          snap;
    logic          data_flag;
    mbcp_pkg::data_class_t dclass;

    // reserve a result slot for everything already in flight
    assign pending = (LW+1)'(out_level) + (LW+1)'(a_valid_reg) + (LW+1)'(b_valid_reg);
    assign mid_pop = !mid_empty && (pending < (LW+1)'(OUT_DEPTH));
    assign snap    = mid_pop && mid_item.last;

    always_comb
    begin
        is_lf = (mid_item.cls == mbcp_pkg::CLS_LF);
        is_cr = (mid_item.cls == mbcp_pkg::CLS_CR);
        // a CR right before the LF is not part of the line
        len_adj = (prev_cr_reg && (line_len_reg != '0)) ? line_len_reg - CW'(1)
                                                        : line_len_reg;
        byte_next     = bump(byte_reg, 1'b1);
        nul_next      = bump(nul_reg, mid_item.cls == mbcp_pkg::CLS_NUL);
        ctl_next      = bump(ctl_reg, mid_item.cls == mbcp_pkg::CLS_CTL);
        print_next    = bump(print_reg, mid_item.cls == mbcp_pkg::CLS_PRINT);
        high_next     = bump(high_reg, mid_item.cls == mbcp_pkg::CLS_HIGH);
        cr_next       = bump(cr_reg, is_cr);
        lf_next       = bump(lf_reg, is_lf);
        crlf_next     = bump(crlf_reg, is_lf && prev_cr_reg);
        prev_cr_next  = is_cr;
        line_len_next = is_lf ? '0 : bump(line_len_reg, 1'b1);
        max_line_next = (is_lf && (len_adj > max_line_reg)) ? len_adj : max_line_reg;
        min_line_next = (is_lf && (len_adj < min_line_reg)) ? len_adj : min_line_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cr_reg  <= 1'b0;
            line_len_reg <= '0;
            byte_reg     <= '0;
            nul_reg      <= '0;
            ctl_reg      <= '0;
            print_reg    <= '0;
            high_reg     <= '0;
            cr_reg       <= '0;
            lf_reg       <= '0;
            crlf_reg     <= '0;
            min_line_reg <= '1;
            max_line_reg <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg <= snap;
            b_valid_reg <= a_valid_reg;
            if (snap)
            begin
                prev_cr_reg  <= 1'b0;
                line_len_reg <= '0;
                byte_reg     <= '0;
                nul_reg      <= '0;
                ctl_reg      <= '0;
                print_reg    <= '0;
                high_reg     <= '0;
                cr_reg       <= '0;
                lf_reg       <= '0;
                crlf_reg     <= '0;
                min_line_reg <= '1;
                max_line_reg <= '0;
            end
            else if (mid_pop)
            begin
                prev_cr_reg  <= prev_cr_next;
                line_len_reg <= line_len_next;
                byte_reg     <= byte_next;
                nul_reg      <= nul_next;
                ctl_reg      <= ctl_next;
                print_reg    <= print_next;
                high_reg     <= high_next;
                cr_reg       <= cr_next;
                lf_reg       <= lf_next;
                crlf_reg     <= crlf_next;
                min_line_reg <= min_line_next;
                max_line_reg <= max_line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            a_byte_reg  <= byte_next;
            a_nul_reg   <= nul_next;
            a_ctl_reg   <= ctl_next;
            a_print_reg <= print_next;
            a_high_reg  <= high_next;
            a_cr_reg    <= cr_next;
            a_lf_reg    <= lf_next;
            a_crlf_reg  <= crlf_next;
            a_min_reg   <= min_line_next;
            a_max_reg   <= max_line_next;
        end
        if (a_valid_reg)
        begin
            b_byte_reg     <= a_byte_reg;
            b_nul_reg      <= a_nul_reg;
            b_ctl_reg      <= a_ctl_reg;
            b_print_reg    <= a_print_reg;
            b_high_reg     <= a_high_reg;
            b_cr_reg       <= a_cr_reg;
            b_lf_reg       <= a_lf_reg;
            b_crlf_reg     <= a_crlf_reg;
            b_min_reg      <= a_min_reg;
            b_max_reg      <= a_max_reg;
            // ctl * div > total; a zero divisor never trips it
            b_prod_reg     <= PRW'(a_ctl_reg) * PRW'(ctl_div);
            b_data_pre_reg <= (CMPW'(a_max_reg) > CMPW'(line_limit)) ||
                              (a_cr_reg != a_crlf_reg);
        end
    end

    always_comb
    begin
        data_flag = b_data_pre_reg || (b_prod_reg > PRW'(b_byte_reg));
        if (b_nul_reg != '0)
        begin
            dclass = mbcp_pkg::DC_BINARY;
        end
        else if (b_high_reg != '0)
        begin
            dclass = data_flag ? mbcp_pkg::DC_EIGHTBIT_DATA : mbcp_pkg::DC_EIGHTBIT_TEXT;
        end
        else
        begin
            dclass = data_flag ? mbcp_pkg::DC_SEVENBIT_DATA : mbcp_pkg::DC_SEVENBIT_TEXT;
        end
    end

    assign out_push = b_valid_reg;

    always_comb
    begin
        out_item.data_class      = dclass;
        out_item.total_bytes     = 32'(b_byte_reg);
        out_item.nul_bytes       = 32'(b_nul_reg);
        out_item.control_bytes   = 32'(b_ctl_reg);
        out_item.printable_bytes = 32'(b_print_reg);
        out_item.high_bit_bytes  = 32'(b_high_reg);
        out_item.cr_bytes        = 32'(b_cr_reg);
        out_item.lf_bytes        = 32'(b_lf_reg);
        out_item.crlf_pairs      = 32'(b_crlf_reg);
        out_item.shortest_line   = 32'(b_min_reg);
        out_item.longest_line    = 32'(b_max_reg);
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (out_level < LW'(OUT_DEPTH)))
        else $error("result written into a full queue");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        snap |=> (byte_reg == '0 && max_line_reg == '0 && a_valid_reg))
        else $error("state not restarted after last byte");

    a_line_order: assert property (@(posedge clk) disable iff (!rst_n)
        (lf_reg != '0) |-> (min_line_reg <= max_line_reg))
        else $error("shortest line above longest line");

    a_crlf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (crlf_reg <= lf_reg) && (crlf_reg <= cr_reg))
        else $error("crlf count exceeds cr or lf count");

endmodule

// ===== dv/tb_mail_byte_class_profiler.sv =====
// Testbench for mail_byte_class_profiler: byte stream stimulus, result prediction and checks.
module tb_mail_byte_class_profiler;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } buf_byte_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [mbcp_pkg::PADDR_W-1:0]   paddr     = '0;
    logic [31:0]                    pwdata    = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           push      = 1'b0;
    logic                           full;
    logic [7:0]                     data_byte = 8'd0;
    logic                           last_byte = 1'b0;
    logic                           empty;
    logic                           pop       = 1'b0;
    logic [2:0]                     data_class;
    logic [31:0]                    total_bytes;
    logic [31:0]                    nul_bytes;
    logic [31:0]                    control_bytes;
    logic [31:0]                    printable_bytes;
    logic [31:0]                    high_bit_bytes;
    logic [31:0]                    cr_bytes;
    logic [31:0]                    lf_bytes;
    logic [31:0]                    crlf_pairs;
    logic [31:0]                    shortest_line;
    logic [31:0]                    longest_line;

    buf_byte_t          pending_bytes[$];
    mbcp_pkg::result_t  expected_profiles[$];
    int          mismatch_count = 0;
    bit          byte_taken     = 1'b0;
    bit          steady         = 1'b0;
    bit          hold_req       = 1'b0;
    int          hold_left      = 0;

    // predictor copy of the configuration and the per-buffer counters
    logic [15:0] line_lim_cfg;
    logic [7:0]  ctl_div_cfg;
    logic        saw_cr;
    logic [31:0] cur_line_len;
    logic [31:0] n_total, n_nul, n_ctl, n_print, n_high, n_cr, n_lf, n_crlf;
    logic [31:0] min_line, max_line;

    mail_byte_class_profiler uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .empty           (empty),
        .pop             (pop),
        .data_class      (data_class),
        .total_bytes     (total_bytes),
        .nul_bytes       (nul_bytes),
        .control_bytes   (control_bytes),
        .printable_bytes (printable_bytes),
        .high_bit_bytes  (high_bit_bytes),
        .cr_bytes        (cr_bytes),
        .lf_bytes        (lf_bytes),
        .crlf_pairs      (crlf_pairs),
        .shortest_line   (shortest_line),
        .longest_line    (longest_line)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

    function automatic void clear_profile();
        saw_cr       = 1'b0;
        cur_line_len = '0;
        n_total      = '0;
        n_nul        = '0;
        n_ctl        = '0;
        n_print      = '0;
        n_high       = '0;
        n_cr         = '0;
        n_lf         = '0;
        n_crlf       = '0;
        min_line     = 32'hffff_ffff;
        max_line     = '0;
    endfunction

    // Advances the counters by one byte; returns 1 with the profile on the last byte.
    function automatic bit profile_byte(input logic [7:0] b, input logic lst,
                                        output mbcp_pkg::result_t prof);
        logic [31:0] len;
        logic [39:0] ctl_scaled;
        logic        too_ctl;
        logic        is_data;
        prof    = '0;
        n_total = sat_inc(n_total);
        if (b == 8'h0a) begin
            n_lf = sat_inc(n_lf);
            len  = cur_line_len;
            if (saw_cr) begin
                n_crlf = sat_inc(n_crlf);
                if (len != 0)
                    len = len - 32'd1;
            end
            if (len > max_line)
                max_line = len;
            if (len < min_line)
                min_line = len;
            cur_line_len = '0;
            saw_cr       = 1'b0;
        end
        else begin
            cur_line_len = sat_inc(cur_line_len);
            saw_cr       = (b == 8'h0d);
            if (b == 8'h0d)
                n_cr = sat_inc(n_cr);
            else if (b == 8'h00)
                n_nul = sat_inc(n_nul);
            else if (b == 8'h09 || (b >= 8'h20 && b <= 8'h7e))
                n_print = sat_inc(n_print);
            else if (b == 8'h7f || b < 8'h20)
                n_ctl = sat_inc(n_ctl);
            else
                n_high = sat_inc(n_high);
        end
        if (!lst)
            return 1'b0;
        ctl_scaled = {8'd0, n_ctl} * {32'd0, ctl_div_cfg};
        too_ctl    = (ctl_div_cfg != 0) && (ctl_scaled > {8'd0, n_total});
        is_data    = (max_line > {16'd0, line_lim_cfg}) || (n_cr != n_crlf) || too_ctl;
        if (n_nul != 0)
            prof.data_class = mbcp_pkg::DC_BINARY;
        else if (n_high != 0)
            prof.data_class = is_data ? mbcp_pkg::DC_EIGHTBIT_DATA
                                      : mbcp_pkg::DC_EIGHTBIT_TEXT;
        else
            prof.data_class = is_data ? mbcp_pkg::DC_SEVENBIT_DATA
                                      : mbcp_pkg::DC_SEVENBIT_TEXT;
        prof.total_bytes     = n_total;
        prof.nul_bytes       = n_nul;
        prof.control_bytes   = n_ctl;
        prof.printable_bytes = n_print;
        prof.high_bit_bytes  = n_high;
        prof.cr_bytes        = n_cr;
        prof.lf_bytes        = n_lf;
        prof.crlf_pairs      = n_crlf;
        prof.shortest_line   = min_line;
        prof.longest_line    = max_line;
        clear_profile();
        return 1'b1;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // sender: a new item goes up once the previous one was taken
    always @(negedge clk) begin
        buf_byte_t cur;
        if (rst_n && (!push || byte_taken)) begin
            if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
                cur = pending_bytes.pop_front();
                push      <= 1'b1;
                data_byte <= cur.value;
                last_byte <= cur.last;
            end
            else begin
                push      <= 1'b0;
                data_byte <= 8'($urandom_range(255));
                last_byte <= 1'($urandom_range(1));
            end
        end
    end

    // receiver: random pop, plus a long hold-off when requested
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else begin
                pop <= steady || ($urandom_range(99) >= 31);
            end
        end
    end

    always @(posedge clk) begin
        mbcp_pkg::result_t prof;
        if (rst_n) begin
            byte_taken = push && !full;
            if (byte_taken) begin
                if (profile_byte(data_byte, last_byte, prof))
                    expected_profiles.push_back(prof);
            end
            if (pop && !empty) begin
                if (expected_profiles.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual class %0d",
                             $time, data_class);
                    mismatch_count++;
                end
                else begin
                    prof = expected_profiles.pop_front();
                    check_field("data_class", {29'd0, prof.data_class}, {29'd0, data_class});
                    check_field("total_bytes", prof.total_bytes, total_bytes);
                    check_field("nul_bytes", prof.nul_bytes, nul_bytes);
                    check_field("control_bytes", prof.control_bytes, control_bytes);
                    check_field("printable_bytes", prof.printable_bytes, printable_bytes);
                    check_field("high_bit_bytes", prof.high_bit_bytes, high_bit_bytes);
                    check_field("cr_bytes", prof.cr_bytes, cr_bytes);
                    check_field("lf_bytes", prof.lf_bytes, lf_bytes);
                    check_field("crlf_pairs", prof.crlf_pairs, crlf_pairs);
                    check_field("shortest_line", prof.shortest_line, shortest_line);
                    check_field("longest_line", prof.longest_line, longest_line);
                end
            end
        end
    end

    task automatic write_reg(input mbcp_pkg::reg_sel_t sel, input logic [31:0] value);
        logic [mbcp_pkg::PADDR_W-1:0] addr;
        addr                        = '0;
        addr[mbcp_pkg::REG_SEL_BIT] = sel;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == mbcp_pkg::REG_LINE_LIMIT)
            line_lim_cfg = value[15:0];
        else
            ctl_div_cfg = value[7:0];
    endtask

    task automatic read_reg(input mbcp_pkg::reg_sel_t sel);
        logic [mbcp_pkg::PADDR_W-1:0] addr;
        logic [31:0]                  want;
        addr                        = '0;
        addr[mbcp_pkg::REG_SEL_BIT] = sel;
        want = (sel == mbcp_pkg::REG_LINE_LIMIT) ? {16'd0, line_lim_cfg}
                                                 : {24'd0, ctl_div_cfg};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field(sel == mbcp_pkg::REG_LINE_LIMIT ? "prdata line_limit" : "prdata ctl_div",
                    want, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits of the write data carry junk; the block keeps only the field
    task automatic program_limits(input logic [15:0] lim, input logic [7:0] div);
        write_reg(mbcp_pkg::REG_LINE_LIMIT, {16'($urandom), lim});
        write_reg(mbcp_pkg::REG_CTL_DIV, {24'($urandom), div});
        read_reg(mbcp_pkg::REG_LINE_LIMIT);
        read_reg(mbcp_pkg::REG_CTL_DIV);
    endtask

    task automatic queue_byte(input logic [7:0] v, input logic lst);
        buf_byte_t it;
        it.value = v;
        it.last  = lst;
        pending_bytes.push_back(it);
    endtask

    // mostly text lines with CRLF or LF; flavors add control, eight-bit and NUL bytes
    task automatic add_buffer(input int len);
        logic [7:0] body[$];
        logic [7:0] b;
        bit         use_nul, use_high, use_ctl;
        int         r;
        use_nul  = ($urandom_range(7) == 0);
        use_high = ($urandom_range(2) == 0);
        use_ctl  = ($urandom_range(1) == 0);
        while (body.size() < len) begin
            r = int'($urandom_range(99));
            if (r < 8 && body.size() + 1 < len) begin
                body.push_back(8'h0d);
                b = 8'h0a;
            end
            else if (r < 14)
                b = 8'h0a;
            else if (r < 17)
                b = 8'h0d;
            else if (r < 21 && use_ctl) begin
                b = 8'($urandom_range(1, 31));
                if (b == 8'h09 || b == 8'h0a || b == 8'h0d)
                    b = 8'h7f;
            end
            else if (r < 27 && use_high)
                b = 8'($urandom_range(128, 255));
            else if (r < 28 && use_nul)
                b = 8'h00;
            else if (r < 31)
                b = 8'($urandom_range(255));
            else if (r < 35)
                b = 8'h09;
            else
                b = 8'($urandom_range(32, 126));
            body.push_back(b);
        end
        for (int i = 0; i < body.size(); i++)
            queue_byte(body[i], i == body.size() - 1);
    endtask

    task automatic fill_phase(input int nbytes, input int max_len);
        int added;
        int len;
        added = 0;
        while (added < nbytes) begin
            len = ($urandom_range(9) == 0) ? int'($urandom_range(1, 200))
                                           : int'($urandom_range(1, max_len));
            add_buffer(len);
            added += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || push || expected_profiles.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        line_lim_cfg = mbcp_pkg::LINE_LIMIT_RST;
        ctl_div_cfg  = mbcp_pkg::CTL_DIV_RST;
        clear_profile();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        read_reg(mbcp_pkg::REG_LINE_LIMIT);
        read_reg(mbcp_pkg::REG_CTL_DIV);

        // one byte each: seven-bit text, binary, eight-bit text
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hff, 1'b1);
        // eight-bit with too many controls
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7f, 1'b1);
        // CRLF on an empty line, lone CR inside a line, unterminated tail
        queue_byte(8'h0d, 1'b0);
        queue_byte(8'h0a, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h0d, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h0a, 1'b0);
        queue_byte(8'h09, 1'b0);
        queue_byte(8'h7e, 1'b0);
        queue_byte(8'h20, 1'b1);
        // bare LF lines and controls at the low end
        queue_byte(8'h0a, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h1f, 1'b0);
        queue_byte(8'h0a, 1'b0);
        queue_byte(8'h41, 1'b1);
        wait_drained();

        program_limits(16'd0, 8'd255);
        fill_phase(120, 24);
        wait_drained();

        program_limits(16'hffff, 8'd1);
        fill_phase(120, 24);
        wait_drained();

        // divisor zero: control ratio never makes data
        program_limits(16'($urandom_range(0, 40)), 8'd0);
        fill_phase(120, 24);
        wait_drained();

        steady = 1'b1;
        program_limits(mbcp_pkg::LINE_LIMIT_RST, mbcp_pkg::CTL_DIV_RST);
        fill_phase(150, 24);
        wait_drained();
        steady = 1'b0;

        // short buffers and a long receiver hold-off fill both queues
        program_limits(16'($urandom_range(0, 40)), 8'($urandom_range(1, 8)));
        fill_phase(120, 6);
        hold_req = 1'b1;
        wait_drained();

        repeat (3) begin
            program_limits(16'(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 40)),
                           8'($urandom_range(1) ? $urandom_range(1, 8)
                                                : $urandom_range(1, 255)));
            fill_phase(120, 24);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS mail_byte_class_profiler");
        else
            $display("FAIL mail_byte_class_profiler");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL mail_byte_class_profiler");
        $finish;
    end

endmodule
